### rtl/wnm_pkg.sv
// Shared constants for the wildcard name matcher: byte codes, register
// indexes and fixed field widths. No dependencies.
`default_nettype none

package wnm_pkg;

  // Pattern storage is fixed at four 64-bit register words.
  localparam int WORD_COUNT      = 4;
  localparam int WORD_W          = 64;
  localparam int BYTE_W          = 8;
  localparam int LEN_RAW_W       = 6;
  localparam int CFG_INDEX_W     = 3;
  localparam int PATTERN_MAX_DEF = 32;

  localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'h00;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

endpackage

`default_nettype wire

### rtl/wnm_cfg.sv
// Pattern register file and the per-position masks derived from it.
// Depends on wnm_pkg.
`default_nettype none

module wnm_cfg #(
  parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [wnm_pkg::CFG_INDEX_W-1:0]     wr_index,
  input  wire logic [wnm_pkg::WORD_W-1:0]          wr_data,
  output logic [PATTERN_MAX-1:0][wnm_pkg::BYTE_W-1:0] pat_bytes,
  output logic [PATTERN_MAX-1:0]                   in_use,
  output logic [PATTERN_MAX-1:0]                   star_mask,
  output logic [PATTERN_MAX:0]                     keep_mask,
  output logic [$clog2(PATTERN_MAX+1)-1:0]         used_len
);
  import wnm_pkg::*;

  localparam int LEN_W    = $clog2(PATTERN_MAX + 1);
  localparam int STORED_B = WORD_COUNT * WORD_W / BYTE_W;

  logic [WORD_COUNT-1:0][WORD_W-1:0] words;
  logic [LEN_RAW_W-1:0]              len_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      words   <= '0;
      len_raw <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PATTERN_WORD_0: words[0] <= wr_data;
        REG_PATTERN_WORD_1: words[1] <= wr_data;
        REG_PATTERN_WORD_2: words[2] <= wr_data;
        REG_PATTERN_WORD_3: words[3] <= wr_data;
        REG_PATTERN_LENGTH: len_raw  <= wr_data[LEN_RAW_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // Lengths past the maximum clamp to it.
  always_comb begin
    if (len_raw > LEN_RAW_W'(PATTERN_MAX)) begin
      used_len = LEN_W'(PATTERN_MAX);
    end else begin
      used_len = len_raw[LEN_W-1:0];
    end
  end

  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_pos
    if (p < STORED_B) begin : g_stored
      localparam int WI = p / (WORD_W / BYTE_W);
      localparam int BI = p % (WORD_W / BYTE_W);
      assign pat_bytes[p] = words[WI][BI*BYTE_W +: BYTE_W];
    end else begin : g_blank
      assign pat_bytes[p] = NUL_BYTE;  // no register behind this position
    end
    assign in_use[p]    = LEN_W'(p) < used_len;
    assign star_mask[p] = in_use[p] && (pat_bytes[p] == STAR_BYTE);
  end

  for (genvar p = 0; p <= PATTERN_MAX; p++) begin : g_keep
    assign keep_mask[p] = LEN_W'(p) <= used_len;
  end

endmodule

`default_nettype wire

### rtl/wnm_closure.sv
// Star closure of a live-position set: a live star also makes the next
// position live. Log-depth prefix network. Depends on wnm_pkg.
`default_nettype none

module wnm_closure #(
  parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic [PATTERN_MAX:0]   set_in,
  input  wire logic [PATTERN_MAX-1:0] star_mask,
  input  wire logic [PATTERN_MAX:0]   keep_mask,
  output logic [PATTERN_MAX:0]        set_out
);
  import wnm_pkg::*;

  localparam int W   = PATTERN_MAX + 1;
  localparam int LVL = $clog2(W);

  // gen: reachable bits; prop: run of stars feeding each position
  logic [LVL:0][W-1:0] gen;
  logic [LVL:0][W-1:0] prop;

  assign gen[0]  = set_in & keep_mask;
  assign prop[0] = {star_mask, 1'b0};

  for (genvar k = 0; k < LVL; k++) begin : g_lvl
    for (genvar i = 0; i < W; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_span
        assign gen[k+1][i]  = gen[k][i] | (prop[k][i] & gen[k][i-(1<<k)]);
        assign prop[k+1][i] = prop[k][i] & prop[k][i-(1<<k)];
      end else begin : g_pass
        assign gen[k+1][i]  = gen[k][i];
        assign prop[k+1][i] = prop[k][i];
      end
    end
  end

  assign set_out = gen[LVL];

endmodule

`default_nettype wire

### rtl/wnm_nfa.sv
// Live-position register and the one-byte advance of the matcher.
// Depends on wnm_pkg and wnm_closure.
`default_nettype none

module wnm_nfa #(
  parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   step,
  input  wire logic [wnm_pkg::BYTE_W-1:0]             byte_in,
  input  wire logic [PATTERN_MAX-1:0][wnm_pkg::BYTE_W-1:0] pat_bytes,
  input  wire logic [PATTERN_MAX-1:0]                 in_use,
  input  wire logic [PATTERN_MAX-1:0]                 star_mask,
  input  wire logic [PATTERN_MAX:0]                   keep_mask,
  input  wire logic [$clog2(PATTERN_MAX+1)-1:0]       used_len,
  output logic                                        hit
);
  import wnm_pkg::*;

  localparam int W = PATTERN_MAX + 1;

  logic [W-1:0] live;
  logic [W-1:0] live_next;
  logic [W-1:0] cur;
  logic [W-1:0] adv;

  // Re-close with the current pattern; it may have changed since the last byte.
  wnm_closure #(.PATTERN_MAX(PATTERN_MAX)) u_close_cur (
    .set_in    (live),
    .star_mask (star_mask),
    .keep_mask (keep_mask),
    .set_out   (cur)
  );

  for (genvar p = 0; p < W; p++) begin : g_adv
    logic stay;
    logic move;
    if (p < PATTERN_MAX) begin : g_stay
      assign stay = cur[p] & star_mask[p];
    end else begin : g_nostay
      assign stay = 1'b0;
    end
    if (p > 0) begin : g_move
      assign move = cur[p-1] & in_use[p-1] & ~star_mask[p-1]
                  & (pat_bytes[p-1] == byte_in);
    end else begin : g_nomove
      assign move = 1'b0;
    end
    assign adv[p] = stay | move;
  end

  wnm_closure #(.PATTERN_MAX(PATTERN_MAX)) u_close_next (
    .set_in    (adv),
    .star_mask (star_mask),
    .keep_mask (keep_mask),
    .set_out   (live_next)
  );

  assign hit = cur[used_len];

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= W'(1);
    end else if (step) begin
      if (byte_in == NUL_BYTE) begin
        live <= W'(1);  // name done, back to start
      end else begin
        live <= live_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/wildcard_name_matcher.sv
// Wildcard name matcher top level: handshake stages, pattern registers and
// the position-set automaton. Depends on wnm_pkg, wnm_cfg, wnm_nfa.
//
// Usage
//   in channel  : name_byte words, one name byte each; a zero byte ends the
//                 name and asks for a result. Pattern '*' matches any run.
//   out channel : one matched word per name, given for the zero byte only.
//   cfg channel : cfg_index 0..3 load pattern words (byte 8k in the low
//                 bits), 4 loads the length. cfg_ready is always high;
//                 other indexes are dropped. Write while no name is open.
// Timing
//   Every byte is taken into an input register, then combinational logic
//   (closure prefix network plus byte compares) updates the live-position
//   register. One byte per cycle sustained unless a held result stalls a zero
//   byte; out_valid rises once the zero byte leaves the input register.
// Stall
//   A held result stalls only a following zero byte in the input register;
//   non-zero bytes keep flowing since they make no word.
// Reset
//   rst (synchronous) clears the pattern, sets length zero, empties both
//   stages and leaves only the start position live.
`default_nettype none

module wildcard_name_matcher #(
  parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      name_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 matched,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wnm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wnm_pkg::WORD_W-1:0]      cfg_data
);
  import wnm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_bytes;
  logic [PATTERN_MAX-1:0]             in_use;
  logic [PATTERN_MAX-1:0]             star_mask;
  logic [PATTERN_MAX:0]               keep_mask;
  logic [LEN_W-1:0]                   used_len;

  // Input register stage
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_is_end;
  logic              s1_fire;
  logic              hit;

  assign cfg_ready = 1'b1;

  wnm_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid & cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .pat_bytes (pat_bytes),
    .in_use    (in_use),
    .star_mask (star_mask),
    .keep_mask (keep_mask),
    .used_len  (used_len)
  );

  assign s1_is_end = (s1_byte == NUL_BYTE);
  // End byte needs the output register free; other bytes never wait.
  assign s1_fire   = s1_valid && (!s1_is_end || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= name_byte;
    end
  end

  wnm_nfa #(.PATTERN_MAX(PATTERN_MAX)) u_nfa (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .byte_in   (s1_byte),
    .pat_bytes (pat_bytes),
    .in_use    (in_use),
    .star_mask (star_mask),
    .keep_mask (keep_mask),
    .used_len  (used_len),
    .hit       (hit)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_end) begin
      matched <= hit;
    end
  end

  // Checks
  a_plain_byte_flows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_is_end |-> s1_fire)
    else $error("non-end byte stalled in input stage");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted byte lost from input stage");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_is_end))
    else $error("result word without an end byte");

  a_end_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_is_end && out_valid && !out_ready |=> s1_valid && s1_is_end)
    else $error("end byte dropped while result stalled");

endmodule

`default_nettype wire
